// ----- design/gmvi_pkg.sv -----
// Grid mesh vertex index generator: shared types, constants and helpers.
// Used by gmvi_ctrl, gmvi_dp, the top level and the assertion checker.
package gmvi_pkg;

    localparam int RES_W     = 8;    // res_x / res_y register width
    localparam int SIDE_W    = 9;    // vertices per side, 2..256
    localparam int POS_W     = 8;    // column / row position
    localparam int COORD_W   = 17;   // u/v, 1.0 = 65536
    localparam int IDX_W     = 16;   // vertex index
    localparam int OFS_W     = 2;    // signed edge offset
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;
    localparam int REM_W     = 9;    // divider partial remainder

    localparam logic [SIDE_W-1:0] MAX_SIDE = 9'd256;

    // quotient bits per division: 16 fraction bits plus the integer bit
    localparam int DIV_STEPS = 17;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIV_STEPS - 1);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RES_X     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RES_Y     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ANTIALIAS = 2'd2;

    // configuration reset values
    localparam logic [RES_W-1:0] RES_X_RST = 8'd4;
    localparam logic [RES_W-1:0] RES_Y_RST = 8'd4;

    // edge offset codes
    localparam logic signed [OFS_W-1:0] OFS_NONE = 2'sb00;
    localparam logic signed [OFS_W-1:0] OFS_PLUS = 2'sb01;
    localparam logic signed [OFS_W-1:0] OFS_MINUS = 2'sb11;

    // controller to datapath commands
    typedef struct packed {
        logic start;   // transaction accepted: fix position, seed dividers
        logic step;    // one divider step
        logic load;    // move the finished vertex into the output register
    } dp_cmd_t;

    // 2 + res, saturated at MAX_SIDE
    function automatic logic [SIDE_W-1:0] side_len(input logic [RES_W-1:0] res);
        logic [SIDE_W-1:0] n;
        n = {1'b0, res} + 9'd2;
        return (n > MAX_SIDE) ? MAX_SIDE : n;
    endfunction

    function automatic logic signed [OFS_W-1:0] edge_off(
        input logic              aa,
        input logic [POS_W-1:0]  pos,
        input logic [SIDE_W-1:0] n
    );
        logic signed [OFS_W-1:0] ofs;
        ofs = OFS_NONE;
        if (aa)
        begin
            if (pos == '0)
                ofs = OFS_PLUS;
            else if ({1'b0, pos} == n - 9'd1)
                ofs = OFS_MINUS;
        end
        return ofs;
    endfunction

endpackage

// ----- design/gmvi_ctrl.sv -----
// Sequencer for the grid mesh vertex index generator.
// Drives the handshakes and issues gmvi_pkg::dp_cmd_t commands to gmvi_dp.
module gmvi_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output gmvi_pkg::dp_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]                  state_reg, state_next;
    logic [gmvi_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        out_free;
    logic                        accept;

    // output register can take a new vertex this cycle
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        in_stall = !((state_reg == ST_IDLE) || ((state_reg == ST_DONE) && out_free));
    end

    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.start  = accept;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_DIV;
                    cnt_next   = '0;
                end
            end
            ST_DIV:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == gmvi_pkg::LAST_STEP)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.load = 1'b1;
                    if (accept)
                    begin
                        state_next = ST_DIV;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = cmd.load || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- design/gmvi_dp.sv -----
// Datapath: configuration registers, grid position, index arithmetic,
// two radix-2 dividers for u/v and the output register. Uses gmvi_pkg.
module gmvi_dp (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [gmvi_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [gmvi_pkg::CFG_DAT_W-1:0]         cfg_data,
    input  logic                                   restart,
    input  gmvi_pkg::dp_cmd_t                      cmd,
    output logic [gmvi_pkg::COORD_W-1:0]           u_coord,
    output logic [gmvi_pkg::COORD_W-1:0]           v_coord,
    output logic signed [gmvi_pkg::OFS_W-1:0]      x_offset,
    output logic signed [gmvi_pkg::OFS_W-1:0]      y_offset,
    output logic                                   has_quad,
    output logic [gmvi_pkg::IDX_W-1:0]             tri0_a,
    output logic [gmvi_pkg::IDX_W-1:0]             tri0_b,
    output logic [gmvi_pkg::IDX_W-1:0]             tri0_c,
    output logic [gmvi_pkg::IDX_W-1:0]             tri1_a,
    output logic [gmvi_pkg::IDX_W-1:0]             tri1_b,
    output logic [gmvi_pkg::IDX_W-1:0]             tri1_c,
    output logic                                   last_vertex
);

    logic [gmvi_pkg::RES_W-1:0]   res_x_reg, res_y_reg;
    logic                         aa_reg;
    logic [gmvi_pkg::SIDE_W-1:0]  cols, rows;
    logic [gmvi_pkg::RES_W-1:0]   div_u, div_v;

    logic [gmvi_pkg::POS_W-1:0]   column_reg, row_reg;
    logic [gmvi_pkg::POS_W-1:0]   column_next, row_next;
    logic [gmvi_pkg::POS_W-1:0]   c_start, r_start;
    logic [gmvi_pkg::SIDE_W-1:0]  c_inc, r_inc;
    logic                         pos_reset;

    logic [gmvi_pkg::POS_W-1:0]   c_reg, r_reg;
    logic [gmvi_pkg::IDX_W-1:0]   here_reg, here_next;
    logic [gmvi_pkg::COORD_W-1:0] prod;

    logic [gmvi_pkg::REM_W-1:0]   rem_u_reg, rem_v_reg, rem_u_next, rem_v_next;
    logic [gmvi_pkg::COORD_W-1:0] q_u_reg, q_v_reg;
    logic                         trial_u, trial_v;
    logic [gmvi_pkg::REM_W-1:0]   sel_u, sel_v;

    logic                         quad;
    logic [gmvi_pkg::IDX_W-1:0]   below, here_p1, below_p1;

    // ---- configuration ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_x_reg <= gmvi_pkg::RES_X_RST;
            res_y_reg <= gmvi_pkg::RES_Y_RST;
            aa_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                gmvi_pkg::REG_RES_X:     res_x_reg <= cfg_data;
                gmvi_pkg::REG_RES_Y:     res_y_reg <= cfg_data;
                gmvi_pkg::REG_ANTIALIAS: aa_reg    <= cfg_data[0];
                default:                 ;
            endcase
        end
    end

    assign cols  = gmvi_pkg::side_len(res_x_reg);
    assign rows  = gmvi_pkg::side_len(res_y_reg);
    assign div_u = gmvi_pkg::RES_W'(cols - 9'd1);
    assign div_v = gmvi_pkg::RES_W'(rows - 9'd1);

    // ---- position walk ----
    // also back to vertex 0 if a shrunk grid left the position outside
    assign pos_reset = restart || ({1'b0, column_reg} >= cols) || ({1'b0, row_reg} >= rows);
    assign c_start   = pos_reset ? '0 : column_reg;
    assign r_start   = pos_reset ? '0 : row_reg;
    assign c_inc     = {1'b0, c_start} + 9'd1;
    assign r_inc     = {1'b0, r_start} + 9'd1;

    always_comb
    begin
        if (c_inc < cols)
        begin
            column_next = c_inc[gmvi_pkg::POS_W-1:0];
            row_next    = r_start;
        end
        else
        begin
            column_next = '0;
            row_next    = (r_inc < rows) ? r_inc[gmvi_pkg::POS_W-1:0] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg <= '0;
            row_reg    <= '0;
        end
        else if (cmd.start)
        begin
            column_reg <= column_next;
            row_reg    <= row_next;
        end
    end

    // ---- linear index: row * cols + column ----
    assign prod      = {9'b0, r_reg} * {8'b0, cols};
    assign here_next = prod[gmvi_pkg::IDX_W-1:0] + {8'b0, c_reg};

    // ---- restoring dividers, one quotient bit per step ----
    // seed remainder is the position itself (never above the divisor)
    assign trial_u    = rem_u_reg >= {1'b0, div_u};
    assign trial_v    = rem_v_reg >= {1'b0, div_v};
    assign sel_u      = trial_u ? (rem_u_reg - {1'b0, div_u}) : rem_u_reg;
    assign sel_v      = trial_v ? (rem_v_reg - {1'b0, div_v}) : rem_v_reg;
    assign rem_u_next = {sel_u[gmvi_pkg::REM_W-2:0], 1'b0};
    assign rem_v_next = {sel_v[gmvi_pkg::REM_W-2:0], 1'b0};

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            c_reg     <= c_start;
            r_reg     <= r_start;
            rem_u_reg <= {1'b0, c_start};
            rem_v_reg <= {1'b0, r_start};
            q_u_reg   <= '0;
            q_v_reg   <= '0;
        end
        else if (cmd.step)
        begin
            rem_u_reg <= rem_u_next;
            rem_v_reg <= rem_v_next;
            q_u_reg   <= {q_u_reg[gmvi_pkg::COORD_W-2:0], trial_u};
            q_v_reg   <= {q_v_reg[gmvi_pkg::COORD_W-2:0], trial_v};
            here_reg  <= here_next;
        end
    end

    // ---- result assembly ----
    assign quad     = ({1'b0, c_reg} < cols - 9'd1) && ({1'b0, r_reg} < rows - 9'd1);
    assign below    = here_reg + {7'b0, cols};
    assign here_p1  = here_reg + 16'd1;
    assign below_p1 = below + 16'd1;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            u_coord     <= q_u_reg;
            v_coord     <= q_v_reg;
            x_offset    <= gmvi_pkg::edge_off(aa_reg, c_reg, cols);
            y_offset    <= gmvi_pkg::edge_off(aa_reg, r_reg, rows);
            has_quad    <= quad;
            tri0_a      <= quad ? here_reg : '0;
            tri0_b      <= quad ? here_p1  : '0;
            tri0_c      <= quad ? below    : '0;
            tri1_a      <= quad ? below    : '0;
            tri1_b      <= quad ? below_p1 : '0;
            tri1_c      <= quad ? here_p1  : '0;
            last_vertex <= ({1'b0, c_reg} == cols - 9'd1) && ({1'b0, r_reg} == rows - 9'd1);
        end
    end

endmodule

// ----- design/grid_mesh_vertex_index_generator.sv -----
// Top level of the grid mesh vertex index generator.
// Instantiates gmvi_ctrl and gmvi_dp; types and constants from gmvi_pkg.
//
// Walks a (2+res_x) by (2+res_y) vertex grid in row order, one vertex per
// input transaction (restart=1 goes back to vertex 0 first). Each output
// transaction carries u/v in 1.0 = 65536 fixed point (truncated), the
// antialiasing edge offsets and, for a vertex off the last row and column,
// the six indices of its quad's two triangles. A vertex passes from
// acceptance to the output register through 17 steps of the two radix-2
// dividers (u and v run side by side, one quotient bit each per cycle)
// and then the done state, which loads the result; a new transaction can
// be taken in the done state when the output register is free. A finished
// vertex waiting there on out_stall holds up acceptance of the next one.
// Configuration writes take effect at once and must only be made while
// the block is idle; a side of 255 extra vertices is clamped to 256. No
// clearing pass after reset.
module grid_mesh_vertex_index_generator (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // configuration write port
    input  logic                                   cfg_we,
    input  logic [gmvi_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [gmvi_pkg::CFG_DAT_W-1:0]         cfg_data,
    // input channel
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   restart,
    // output channel
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [gmvi_pkg::COORD_W-1:0]           u_coord,
    output logic [gmvi_pkg::COORD_W-1:0]           v_coord,
    output logic signed [gmvi_pkg::OFS_W-1:0]      x_offset,
    output logic signed [gmvi_pkg::OFS_W-1:0]      y_offset,
    output logic                                   has_quad,
    output logic [gmvi_pkg::IDX_W-1:0]             tri0_a,
    output logic [gmvi_pkg::IDX_W-1:0]             tri0_b,
    output logic [gmvi_pkg::IDX_W-1:0]             tri0_c,
    output logic [gmvi_pkg::IDX_W-1:0]             tri1_a,
    output logic [gmvi_pkg::IDX_W-1:0]             tri1_b,
    output logic [gmvi_pkg::IDX_W-1:0]             tri1_c,
    output logic                                   last_vertex
);

    // start / step / load from the sequencer
    gmvi_pkg::dp_cmd_t cmd;

    gmvi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // position, index maths, dividers and the output register
    gmvi_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .restart     (restart),
        .cmd         (cmd),
        .u_coord     (u_coord),
        .v_coord     (v_coord),
        .x_offset    (x_offset),
        .y_offset    (y_offset),
        .has_quad    (has_quad),
        .tri0_a      (tri0_a),
        .tri0_b      (tri0_b),
        .tri0_c      (tri0_c),
        .tri1_a      (tri1_a),
        .tri1_b      (tri1_b),
        .tri1_c      (tri1_c),
        .last_vertex (last_vertex)
    );

endmodule

// ----- design/gmvi_chk.sv -----
// Port-level assertion checker for grid_mesh_vertex_index_generator.
// Bound to the top level below; widths from gmvi_pkg.
module gmvi_chk (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    input  logic                                   in_stall,
    input  logic                                   out_valid,
    input  logic                                   out_stall,
    input  logic [gmvi_pkg::COORD_W-1:0]           u_coord,
    input  logic [gmvi_pkg::COORD_W-1:0]           v_coord,
    input  logic                                   has_quad,
    input  logic [gmvi_pkg::IDX_W-1:0]             tri0_a,
    input  logic [gmvi_pkg::IDX_W-1:0]             tri0_b,
    input  logic [gmvi_pkg::IDX_W-1:0]             tri0_c,
    input  logic [gmvi_pkg::IDX_W-1:0]             tri1_a,
    input  logic [gmvi_pkg::IDX_W-1:0]             tri1_b,
    input  logic [gmvi_pkg::IDX_W-1:0]             tri1_c,
    input  logic                                   last_vertex
);

    // a waiting output transaction stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output transaction dropped while stalled");

    // one vertex at a time: the divider is busy after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while divider busy");

    // off-quad vertices carry zero triangle indices
    a_no_quad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_quad |-> (tri0_a == '0) && (tri0_b == '0) && (tri0_c == '0)
            && (tri1_a == '0) && (tri1_b == '0) && (tri1_c == '0))
        else $error("triangle indices set without a quad");

    // the final vertex sits at u = v = 1.0 and starts no quad
    a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_vertex |-> !has_quad && (u_coord == 17'h10000)
            && (v_coord == 17'h10000))
        else $error("last vertex not at the far corner");

endmodule

bind grid_mesh_vertex_index_generator gmvi_chk u_gmvi_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .u_coord     (u_coord),
    .v_coord     (v_coord),
    .has_quad    (has_quad),
    .tri0_a      (tri0_a),
    .tri0_b      (tri0_b),
    .tri0_c      (tri0_c),
    .tri1_a      (tri1_a),
    .tri1_b      (tri1_b),
    .tri1_c      (tri1_c),
    .last_vertex (last_vertex)
);
